/* src/asn1tlv_pkg.sv */
// shared types, codes and constants of the tlv stream parser
`default_nettype none

package asn1tlv_pkg;

   localparam int MaxDepthDefault       = 16;
   localparam int MaxLengthBytesDefault = 4;

   localparam int PosWidth = 34;
   localparam logic [PosWidth-1:0] PosMax = 34'h3_FFFF_FFFF;

   // parse phases
   localparam logic [2:0] PH_TAG  = 3'd0;
   localparam logic [2:0] PH_LEN1 = 3'd1;
   localparam logic [2:0] PH_LENX = 3'd2;
   localparam logic [2:0] PH_BODY = 3'd3;
   localparam logic [2:0] PH_PAD  = 3'd4;

   // byte roles
   localparam logic [2:0] ROLE_TAG     = 3'd0;
   localparam logic [2:0] ROLE_LEN1    = 3'd1;
   localparam logic [2:0] ROLE_LENX    = 3'd2;
   localparam logic [2:0] ROLE_CONTENT = 3'd3;
   localparam logic [2:0] ROLE_PAD     = 3'd4;
   localparam logic [2:0] ROLE_IGNORED = 3'd5;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED = 3'd1;
   localparam logic [2:0] ERR_BEYOND    = 3'd2;
   localparam logic [2:0] ERR_LEN_BYTES = 3'd3;
   localparam logic [2:0] ERR_CPLX_TAG  = 3'd4;
   localparam logic [2:0] ERR_EXTRA     = 3'd5;
   localparam logic [2:0] ERR_TOO_DEEP  = 3'd6;

   localparam logic [7:0] TagExplicitMask = 8'hA0;
   localparam logic [4:0] TagNumberHigh   = 5'h1F;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [4:0]  nest_depth;
      logic [7:0]  tag_byte;
      logic        explicit_mark;
      logic        constructed_mark;
      logic        header_done;
      logic [31:0] body_length;
      logic [4:0]  levels_closed;
      logic        top_complete;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic                push;
      logic [PosWidth-1:0] end_pos;
   } stk_wr_type;

endpackage

`default_nettype wire

/* src/asn1_tlv_stream_parser_top.sv */
// top level of the asn.1 ber tlv stream parser
//
// one encoded buffer enters as a stream of byte beats on req_; each beat carries the
// byte and a last flag on the final byte of the buffer. for every byte exactly one
// result beat leaves on rsp_: role, depth, tag, marks, decoded length on the byte that
// ends a header, objects closed on that byte, top-object-done flag and sticky error.
// a request beat is decoded from the input register into the result register; one byte
// is taken every cycle while not stalled, set by the single decode step between the
// input and result registers (open-object ends are checked against the top entry only).
// after the last byte the parser restarts for the next buffer with no gap.
// reset clears the handshake and parser state; the end stack needs no clearing.
// when the receiver holds rsp_stall the result holds; an empty input register still
// takes one more request beat, and once it holds one req_stall follows rsp_stall
// in the same cycle until the stall clears.
`default_nettype none

module asn1_tlv_stream_parser_top #(
   parameter int MAX_DEPTH = asn1tlv_pkg::MaxDepthDefault,
   parameter int MAX_LENGTH_BYTES = asn1tlv_pkg::MaxLengthBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_byte_role,
   output logic [4:0]       rsp_nest_depth,
   output logic [7:0]       rsp_tag_byte,
   output logic             rsp_explicit_mark,
   output logic             rsp_constructed_mark,
   output logic             rsp_header_done,
   output logic [31:0]      rsp_body_length,
   output logic [4:0]       rsp_levels_closed,
   output logic             rsp_top_complete,
   output logic [2:0]       rsp_error_code
);

   asn1tlv_pkg::rsp_type rsp_beat;

   asn1tlv_top_regs #(
      .MAX_DEPTH        (MAX_DEPTH),
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_regs (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_beat      (rsp_beat)
   );

   assign rsp_byte_role        = rsp_beat.byte_role;
   assign rsp_nest_depth       = rsp_beat.nest_depth;
   assign rsp_tag_byte         = rsp_beat.tag_byte;
   assign rsp_explicit_mark    = rsp_beat.explicit_mark;
   assign rsp_constructed_mark = rsp_beat.constructed_mark;
   assign rsp_header_done      = rsp_beat.header_done;
   assign rsp_body_length      = rsp_beat.body_length;
   assign rsp_levels_closed    = rsp_beat.levels_closed;
   assign rsp_top_complete     = rsp_beat.top_complete;
   assign rsp_error_code       = rsp_beat.error_code;

endmodule

`default_nettype wire

/* src/asn1tlv_stack.sv */
// end-position stack of open constructed objects with close-group base index
`default_nettype none

module asn1tlv_stack #(
   parameter int MAX_DEPTH = asn1tlv_pkg::MaxDepthDefault,
   localparam int LevelWidth = $clog2(MAX_DEPTH + 1),
   localparam int IdxWidth = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire asn1tlv_pkg::stk_wr_type          wr,
   input  wire logic [LevelWidth-1:0]            level,
   output logic [asn1tlv_pkg::PosWidth-1:0]      top_end,
   output logic [LevelWidth-1:0]                 top_base
);

   logic [asn1tlv_pkg::PosWidth-1:0] end_ff [MAX_DEPTH];
   logic [LevelWidth-1:0]            base_ff [MAX_DEPTH];
   logic [asn1tlv_pkg::PosWidth-1:0] end_in;
   logic [LevelWidth-1:0]            base_in;
   logic [LevelWidth-1:0]            level_m1;
   logic [IdxWidth-1:0]              top_idx;
   logic [IdxWidth-1:0]              wr_idx;

   assign level_m1 = level - LevelWidth'(1);
   assign top_idx  = level_m1[IdxWidth-1:0];
   assign wr_idx   = level[IdxWidth-1:0];
   assign top_end  = end_ff[top_idx];
   assign top_base = base_ff[top_idx];

   // objects sharing an end close together: remember where the group starts
   assign end_in  = wr.end_pos;
   assign base_in = (level != '0 && wr.end_pos == top_end) ? top_base : level;

   always_ff @(posedge clock) begin
      if (wr_en && wr.push) begin
         end_ff[wr_idx]  <= end_in;
         base_ff[wr_idx] <= base_in;
      end
   end

endmodule

`default_nettype wire

/* src/asn1tlv_decode.sv */
// per-byte decode: next parser state, stack push and result beat
`default_nettype none

module asn1tlv_decode #(
   parameter int MAX_DEPTH = asn1tlv_pkg::MaxDepthDefault,
   parameter int MAX_LENGTH_BYTES = asn1tlv_pkg::MaxLengthBytesDefault,
   localparam int LevelWidth = $clog2(MAX_DEPTH + 1)
) (
   input  wire logic [7:0]                        data_byte,
   input  wire logic                              last_byte,
   input  wire logic [2:0]                        phase,
   input  wire logic [asn1tlv_pkg::PosWidth-1:0]  pos,
   input  wire logic [LevelWidth-1:0]             level,
   input  wire logic [7:0]                        tag,
   input  wire logic [31:0]                       acc,
   input  wire logic [2:0]                        left,
   input  wire logic [2:0]                        err,
   input  wire logic                              top_ended,
   input  wire logic [asn1tlv_pkg::PosWidth-1:0]  top_end,
   input  wire logic [LevelWidth-1:0]             top_base,
   output logic [2:0]                             phase_n,
   output logic [asn1tlv_pkg::PosWidth-1:0]       pos_n,
   output logic [LevelWidth-1:0]                  level_n,
   output logic [7:0]                             tag_n,
   output logic [31:0]                            acc_n,
   output logic [2:0]                             left_n,
   output logic [2:0]                             err_n,
   output logic                                   top_ended_n,
   output asn1tlv_pkg::stk_wr_type                push,
   output asn1tlv_pkg::rsp_type                   rsp
);

   localparam int PW = asn1tlv_pkg::PosWidth;

   logic [PW:0]           pos_inc;
   logic [PW-1:0]         pos1;
   logic                  has_parent;
   logic                  beyond_next;
   logic [31:0]           acc_shift;
   logic [2:0]            left_dec;
   logic [31:0]           len_sel;
   logic [PW+1:0]         end_sum;
   logic [PW-1:0]         end_sat;
   logic                  beyond_end;
   logic                  close_hit;
   logic [LevelWidth-1:0] close_level;
   logic [LevelWidth:0]   closed_cnt;
   logic                  do_finish;
   logic                  do_close;
   logic [2:0]            err_step;
   logic                  top_step;

   assign pos_inc    = {1'b0, pos} + (PW+1)'(1);
   assign pos1       = (pos == asn1tlv_pkg::PosMax) ? asn1tlv_pkg::PosMax : pos_inc[PW-1:0];
   assign has_parent = (level != '0);
   // next position compared unsaturated, so the last position counts as past any end
   assign beyond_next = has_parent && (pos_inc > {1'b0, top_end});

   assign acc_shift = {acc[23:0], data_byte};
   assign left_dec  = (left != 3'd0) ? left - 3'd1 : left;

   always_comb begin
      case (phase)
         asn1tlv_pkg::PH_LEN1: len_sel = data_byte[7] ? 32'd0 : {24'd0, data_byte};
         asn1tlv_pkg::PH_LENX: len_sel = acc_shift;
         default:              len_sel = 32'd0;
      endcase
   end

   // declared end of the object, saturated like the byte position
   assign end_sum    = (PW+2)'(pos) + (PW+2)'(1) + (PW+2)'(len_sel);
   assign end_sat    = (end_sum > (PW+2)'(asn1tlv_pkg::PosMax)) ? asn1tlv_pkg::PosMax
                                                                : end_sum[PW-1:0];
   assign beyond_end = has_parent && (end_sat > top_end);

   // the whole group of objects ending with the top entry closes at once
   assign close_hit   = has_parent && (top_end == pos1);
   assign close_level = close_hit ? top_base : level;
   assign closed_cnt  = (LevelWidth+1)'(1) + (LevelWidth+1)'(level)
                        - (LevelWidth+1)'(close_level);

   always_comb begin
      phase_n   = phase;
      level_n   = level;
      tag_n     = tag;
      acc_n     = acc;
      left_n    = left;
      err_step  = err;
      top_step  = top_ended;
      push      = '0;
      rsp       = '0;
      do_finish = 1'b0;
      do_close  = 1'b0;

      if (err != asn1tlv_pkg::ERR_NONE) begin
         rsp.byte_role = asn1tlv_pkg::ROLE_IGNORED;
      end else begin
         rsp.nest_depth       = 5'(level);
         rsp.tag_byte         = tag;
         rsp.explicit_mark    = ((tag & asn1tlv_pkg::TagExplicitMask)
                                 == asn1tlv_pkg::TagExplicitMask);
         rsp.constructed_mark = tag[5];
         case (phase)
            asn1tlv_pkg::PH_TAG: begin
               rsp.byte_role        = asn1tlv_pkg::ROLE_TAG;
               rsp.tag_byte         = data_byte;
               rsp.explicit_mark    = ((data_byte & asn1tlv_pkg::TagExplicitMask)
                                       == asn1tlv_pkg::TagExplicitMask);
               rsp.constructed_mark = data_byte[5];
               tag_n = data_byte;
               if (!data_byte[5] && data_byte[4:0] == asn1tlv_pkg::TagNumberHigh) begin
                  err_step = asn1tlv_pkg::ERR_CPLX_TAG;
               end else begin
                  phase_n = asn1tlv_pkg::PH_LEN1;
               end
            end
            asn1tlv_pkg::PH_LEN1: begin
               rsp.byte_role = asn1tlv_pkg::ROLE_LEN1;
               if (beyond_next) begin
                  err_step = asn1tlv_pkg::ERR_BEYOND;
               end else if (data_byte[7]) begin
                  if (data_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
                     err_step = asn1tlv_pkg::ERR_LEN_BYTES;
                  end else if (data_byte[6:0] == 7'd0) begin
                     do_finish = 1'b1;
                  end else begin
                     left_n  = data_byte[2:0];
                     acc_n   = 32'd0;
                     phase_n = asn1tlv_pkg::PH_LENX;
                  end
               end else begin
                  do_finish = 1'b1;
               end
            end
            asn1tlv_pkg::PH_LENX: begin
               rsp.byte_role = asn1tlv_pkg::ROLE_LENX;
               if (beyond_next) begin
                  err_step = asn1tlv_pkg::ERR_BEYOND;
               end else begin
                  acc_n  = acc_shift;
                  left_n = left_dec;
                  if (left_dec == 3'd0) begin
                     do_finish = 1'b1;
                  end
               end
            end
            asn1tlv_pkg::PH_BODY: begin
               rsp.byte_role = asn1tlv_pkg::ROLE_CONTENT;
               acc_n = (acc != 32'd0) ? acc - 32'd1 : acc;
               if (acc <= 32'd1) begin
                  do_close = 1'b1;
               end
            end
            default: begin
               rsp.byte_role        = asn1tlv_pkg::ROLE_PAD;
               rsp.nest_depth       = 5'd0;
               rsp.tag_byte         = 8'd0;
               rsp.explicit_mark    = 1'b0;
               rsp.constructed_mark = 1'b0;
               if (data_byte != 8'd0) begin
                  err_step = asn1tlv_pkg::ERR_EXTRA;
               end
            end
         endcase

         if (do_finish) begin
            rsp.header_done = 1'b1;
            rsp.body_length = len_sel;
            if (beyond_end) begin
               err_step = asn1tlv_pkg::ERR_BEYOND;
            end else if (len_sel == 32'd0) begin
               do_close = 1'b1;
            end else if (tag[5]) begin
               if (level >= LevelWidth'(MAX_DEPTH)) begin
                  err_step = asn1tlv_pkg::ERR_TOO_DEEP;
               end else begin
                  push.push    = 1'b1;
                  push.end_pos = end_sat;
                  level_n      = level + LevelWidth'(1);
                  phase_n      = asn1tlv_pkg::PH_TAG;
               end
            end else begin
               acc_n   = len_sel;
               phase_n = asn1tlv_pkg::PH_BODY;
            end
         end

         if (do_close) begin
            rsp.levels_closed = 5'(closed_cnt);
            level_n = close_level;
            if (close_level == '0) begin
               top_step = 1'b1;
               phase_n  = asn1tlv_pkg::PH_PAD;
            end else begin
               phase_n  = asn1tlv_pkg::PH_TAG;
            end
         end
      end

      if (last_byte && err_step == asn1tlv_pkg::ERR_NONE && !top_step) begin
         err_step = asn1tlv_pkg::ERR_TRUNCATED;
      end
      rsp.top_complete = top_step;
      rsp.error_code   = err_step;

      pos_n       = pos1;
      err_n       = err_step;
      top_ended_n = top_step;

      // end of buffer: start over for the next one
      if (last_byte) begin
         phase_n     = asn1tlv_pkg::PH_TAG;
         pos_n       = '0;
         level_n     = '0;
         tag_n       = 8'd0;
         acc_n       = 32'd0;
         left_n      = 3'd0;
         err_n       = asn1tlv_pkg::ERR_NONE;
         top_ended_n = 1'b0;
      end
   end

endmodule

`default_nettype wire

/* src/asn1tlv_top_regs.sv */
// input, parser state and result registers with the valid/stall handshake
`default_nettype none

module asn1tlv_top_regs #(
   parameter int MAX_DEPTH = asn1tlv_pkg::MaxDepthDefault,
   parameter int MAX_LENGTH_BYTES = asn1tlv_pkg::MaxLengthBytesDefault,
   localparam int LevelWidth = $clog2(MAX_DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output asn1tlv_pkg::rsp_type      rsp_beat
);

   localparam int PW = asn1tlv_pkg::PosWidth;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   asn1tlv_pkg::rsp_type out_ff, rsp_next;

   logic [2:0]            phase_ff, phase_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic [7:0]            tag_ff, tag_in;
   logic [31:0]           acc_ff, acc_in;
   logic [2:0]            left_ff, left_in;
   logic [2:0]            err_ff, err_in;
   logic                  top_ended_ff, top_ended_in;

   logic                    out_adv;
   logic                    step;
   logic                    in_load;
   asn1tlv_pkg::stk_wr_type push;
   logic [PW-1:0]           top_end;
   logic [LevelWidth-1:0]   top_base;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_adv;
   assign in_load   = !in_valid_ff || out_adv;
   assign req_stall = !in_load;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   asn1tlv_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
      .clock    (clock),
      .wr_en    (step),
      .wr       (push),
      .level    (level_ff),
      .top_end  (top_end),
      .top_base (top_base)
   );

   asn1tlv_decode #(
      .MAX_DEPTH        (MAX_DEPTH),
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_decode (
      .data_byte   (in_byte_ff),
      .last_byte   (in_last_ff),
      .phase       (phase_ff),
      .pos         (pos_ff),
      .level       (level_ff),
      .tag         (tag_ff),
      .acc         (acc_ff),
      .left        (left_ff),
      .err         (err_ff),
      .top_ended   (top_ended_ff),
      .top_end     (top_end),
      .top_base    (top_base),
      .phase_n     (phase_in),
      .pos_n       (pos_in),
      .level_n     (level_in),
      .tag_n       (tag_in),
      .acc_n       (acc_in),
      .left_n      (left_in),
      .err_n       (err_in),
      .top_ended_n (top_ended_in),
      .push        (push),
      .rsp         (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= asn1tlv_pkg::PH_TAG;
         pos_ff       <= '0;
         level_ff     <= '0;
         tag_ff       <= 8'd0;
         acc_ff       <= 32'd0;
         left_ff      <= 3'd0;
         err_ff       <= asn1tlv_pkg::ERR_NONE;
         top_ended_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            level_ff     <= level_in;
            tag_ff       <= tag_in;
            acc_ff       <= acc_in;
            left_ff      <= left_in;
            err_ff       <= err_in;
            top_ended_ff <= top_ended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (step) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_ff;

`ifndef NO_ASSERTIONS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LevelWidth'(MAX_DEPTH))
      else $error("stack level above depth");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && in_last_ff) |=> (level_ff == '0 && phase_ff == asn1tlv_pkg::PH_TAG &&
                                err_ff == asn1tlv_pkg::ERR_NONE && pos_ff == '0))
      else $error("parser not restarted after last beat");

   a_ignored_has_err: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.byte_role == asn1tlv_pkg::ROLE_IGNORED)
         |-> (out_ff.error_code != asn1tlv_pkg::ERR_NONE))
      else $error("ignored beat without error");

   a_header_role: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.header_done)
         |-> (out_ff.byte_role == asn1tlv_pkg::ROLE_LEN1 ||
              out_ff.byte_role == asn1tlv_pkg::ROLE_LENX))
      else $error("header end on a non-length beat");

   a_pad_after_top: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.byte_role == asn1tlv_pkg::ROLE_PAD) |-> out_ff.top_complete)
      else $error("padding beat before top object ended");
`endif

endmodule

`default_nettype wire

/* tb/tb_asn1_tlv_stream_parser_top.sv */
// self-checking testbench of the tlv stream parser: tree buffers, error cases, random stalls
`default_nettype none

module tb_asn1_tlv_stream_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import asn1tlv_pkg::*;

   localparam int MaxDepth       = MaxDepthDefault;
   localparam int MaxLengthBytes = MaxLengthBytesDefault;
   localparam int TotalItems     = 550;
   localparam int LongHoldCycles = 300;
   localparam int CycleLimit     = 200000;
   localparam int MaxReports     = 10;

   typedef logic [7:0] bytes_t[$];

   // shadow of the parser: predicts one result beat per accepted byte beat
   class tlv_scoreboard;
      rsp_type     expected_q[$];
      rsp_type     cur;
      logic [2:0]  phase;
      logic [33:0] pos;
      logic [33:0] end_stack[MaxDepth];
      int unsigned level;
      logic [7:0]  cur_tag;
      logic [31:0] len_acc;
      int unsigned len_left;
      logic [2:0]  err;
      bit          top_done;
      int unsigned fail_count;

      function new();
         for (int i = 0; i < MaxDepth; i++) end_stack[i] = '0;
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         phase    = PH_TAG;
         pos      = '0;
         level    = 0;
         cur_tag  = '0;
         len_acc  = '0;
         len_left = 0;
         err      = ERR_NONE;
         top_done = 1'b0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function logic [33:0] next_pos();
         return (pos == PosMax) ? PosMax : pos + 34'd1;
      endfunction

      function bit past_parent(logic [35:0] p);
         return (level > 0) && (p > {2'b00, end_stack[level-1]});
      endfunction

      // pops every open object ending at end_p, returns how many objects closed
      function int unsigned close_objects(logic [33:0] end_p);
         int unsigned n;
         n = 1;
         while (level > 0 && end_stack[level-1] == end_p) begin
            level--;
            n++;
         end
         if (level == 0) begin
            top_done = 1'b1;
            phase    = PH_PAD;
         end else begin
            phase = PH_TAG;
         end
         return n;
      endfunction

      function void fill_tag();
         cur.nest_depth       = 5'(level);
         cur.tag_byte         = cur_tag;
         cur.explicit_mark    = (cur_tag & TagExplicitMask) == TagExplicitMask;
         cur.constructed_mark = cur_tag[5];
      endfunction

      function void end_header(logic [31:0] len);
         logic [35:0] e;
         e = {2'b00, pos} + 36'd1 + {4'h0, len};
         if (e > {2'b00, PosMax}) e = {2'b00, PosMax};
         cur.header_done = 1'b1;
         cur.body_length = len;
         if (past_parent(e)) begin
            err = ERR_BEYOND;
         end else if (len == 0) begin
            cur.levels_closed = 5'(close_objects(next_pos()));
         end else if (cur_tag[5]) begin
            if (level >= MaxDepth) begin
               err = ERR_TOO_DEEP;
            end else begin
               end_stack[level] = e[33:0];
               level++;
               phase = PH_TAG;
            end
         end else begin
            len_acc = len;
            phase   = PH_BODY;
         end
      endfunction

      function logic [2:0] note_byte(logic [7:0] b, bit last);
         int unsigned n;
         cur = '0;
         if (err != ERR_NONE) begin
            cur.byte_role = ROLE_IGNORED;
         end else begin
            case (phase)
               PH_TAG: begin
                  cur_tag       = b;
                  cur.byte_role = ROLE_TAG;
                  fill_tag();
                  if (!b[5] && b[4:0] == TagNumberHigh) err = ERR_CPLX_TAG;
                  else phase = PH_LEN1;
               end
               PH_LEN1: begin
                  cur.byte_role = ROLE_LEN1;
                  fill_tag();
                  if (past_parent({2'b00, pos} + 36'd1)) begin
                     err = ERR_BEYOND;
                  end else if (b[7]) begin
                     n = {25'd0, b[6:0]};
                     if (n > MaxLengthBytes) begin
                        err = ERR_LEN_BYTES;
                     end else if (n == 0) begin
                        end_header('0);
                     end else begin
                        len_left = n;
                        len_acc  = '0;
                        phase    = PH_LENX;
                     end
                  end else begin
                     end_header({24'h0, b});
                  end
               end
               PH_LENX: begin
                  cur.byte_role = ROLE_LENX;
                  fill_tag();
                  if (past_parent({2'b00, pos} + 36'd1)) begin
                     err = ERR_BEYOND;
                  end else begin
                     len_acc = {len_acc[23:0], b};
                     if (len_left > 0) len_left--;
                     if (len_left == 0) end_header(len_acc);
                  end
               end
               PH_BODY: begin
                  cur.byte_role = ROLE_CONTENT;
                  fill_tag();
                  if (len_acc > 0) len_acc--;
                  if (len_acc == 0) cur.levels_closed = 5'(close_objects(next_pos()));
               end
               default: begin
                  cur.byte_role = ROLE_PAD;
                  if (b != 8'h00) err = ERR_EXTRA;
               end
            endcase
         end
         if (pos != PosMax) pos++;
         if (last && err == ERR_NONE && !top_done) err = ERR_TRUNCATED;
         cur.top_complete = top_done;
         cur.error_code   = err;
         expected_q = {expected_q, cur};
         if (last) restart();
         return cur.byte_role;
      endfunction

      function string show(rsp_type r);
         return $sformatf("role=%0d depth=%0d tag=%02h expl=%0d cons=%0d hdr=%0d len=%08h %s",
                          r.byte_role, r.nest_depth, r.tag_byte, r.explicit_mark,
                          r.constructed_mark, r.header_done, r.body_length,
                          $sformatf("closed=%0d top=%0d err=%0d", r.levels_closed,
                                    r.top_complete, r.error_code));
      endfunction

      function void check_result(rsp_type act);
         rsp_type want;
         if (expected_q.size() == 0) begin
            if (fail_count < MaxReports) $display("unexpected result beat: %s", show(act));
            fail_count++;
            return;
         end
         want = expected_q.pop_front();
         if (want.byte_role !== act.byte_role || want.nest_depth !== act.nest_depth ||
             want.tag_byte !== act.tag_byte || want.explicit_mark !== act.explicit_mark ||
             want.constructed_mark !== act.constructed_mark ||
             want.header_done !== act.header_done || want.body_length !== act.body_length ||
             want.levels_closed !== act.levels_closed ||
             want.top_complete !== act.top_complete || want.error_code !== act.error_code) begin
            if (fail_count < MaxReports) begin
               $display("mismatch exp: %s", show(want));
               $display("         act: %s", show(act));
            end
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_byte_role;
   logic [4:0]  rsp_nest_depth;
   logic [7:0]  rsp_tag_byte;
   logic        rsp_explicit_mark;
   logic        rsp_constructed_mark;
   logic        rsp_header_done;
   logic [31:0] rsp_body_length;
   logic [4:0]  rsp_levels_closed;
   logic        rsp_top_complete;
   logic [2:0]  rsp_error_code;
   rsp_type     seen_rsp;

   tlv_scoreboard sb;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_request = 1'b0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;

   asn1_tlv_stream_parser_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_byte_role        (rsp_byte_role),
      .rsp_nest_depth       (rsp_nest_depth),
      .rsp_tag_byte         (rsp_tag_byte),
      .rsp_explicit_mark    (rsp_explicit_mark),
      .rsp_constructed_mark (rsp_constructed_mark),
      .rsp_header_done      (rsp_header_done),
      .rsp_body_length      (rsp_body_length),
      .rsp_levels_closed    (rsp_levels_closed),
      .rsp_top_complete     (rsp_top_complete),
      .rsp_error_code       (rsp_error_code)
   );

   assign seen_rsp = {rsp_byte_role, rsp_nest_depth, rsp_tag_byte, rsp_explicit_mark,
                      rsp_constructed_mark, rsp_header_done, rsp_body_length,
                      rsp_levels_closed, rsp_top_complete, rsp_error_code};

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(seen_rsp);
   end

   // receiver: random stall, or one long hold counted here
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHoldCycles) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic logic [7:0] rand_tag(bit constructed);
      logic [7:0] t;
      t    = 8'($urandom);
      t[5] = constructed;
      if (!constructed && t[4:0] == TagNumberHigh) t[4:0] = 5'h1E;
      return t;
   endfunction

   function automatic bytes_t encode_len(logic [31:0] len, bit long_form);
      bytes_t q;
      int     n;
      if (!long_form && len < 128) begin
         q = {q, len[7:0]};
         return q;
      end
      if (len == 0 && $urandom_range(1) == 1) begin
         q = {q, 8'h80};
         return q;
      end
      n = (len > 32'hFF_FFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
      // sometimes pad the long form with leading zero bytes
      if ($urandom_range(3) == 0) n = $urandom_range(MaxLengthBytes, n);
      q = {q, 8'h80 | 8'(n)};
      for (int i = n - 1; i >= 0; i--) q = {q, len[8*i +: 8]};
      return q;
   endfunction

   function automatic bytes_t wrap_tlv(logic [7:0] tag, bytes_t body);
      bytes_t q;
      q = encode_len(body.size(), $urandom_range(7) == 0);
      q.push_front(tag);
      return {q, body};
   endfunction

   function automatic bytes_t make_prim();
      bytes_t body;
      int     n;
      if ($urandom_range(7) == 0) return wrap_tlv(rand_tag(1'b1), body);
      n = ($urandom_range(39) == 0) ? $urandom_range(280, 128) : $urandom_range(6);
      repeat (n) body = {body, 8'($urandom)};
      return wrap_tlv(rand_tag(1'b0), body);
   endfunction

   function automatic bytes_t make_siblings(int k);
      bytes_t q;
      repeat (k) q = {q, make_prim()};
      return q;
   endfunction

   // wraps inner in depth constructed levels; bare leaves out siblings so all levels close at once
   function automatic bytes_t nest(bytes_t inner, int depth, bit bare);
      bytes_t q;
      q = inner;
      for (int lvl = 0; lvl < depth; lvl++) begin
         if (!bare) q = {make_siblings($urandom_range(2)), q, make_siblings($urandom_range(1))};
         q = wrap_tlv(rand_tag(1'b1), q);
      end
      return q;
   endfunction

   task automatic send_byte(logic [7:0] d, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.note_byte(d, last));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_buffer(bytes_t q);
      for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
   endtask

   // sender pauses until every result beat is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic run_random(int unsigned target);
      bytes_t q;
      int     kind;
      int     cut;
      while (items_sent < target) begin
         if ($urandom_range(24) == 0) q = nest(make_prim(), $urandom_range(17, 14), 1'b1);
         else q = nest(make_prim(), $urandom_range(4), 1'b0);
         kind = $urandom_range(99);
         if (kind < 70) begin
            repeat ($urandom_range(3)) q = {q, 8'h00};
         end else if (kind < 80) begin
            cut = $urandom_range(q.size() - 1, 1);
            q = q[0:cut-1];
         end else if (kind < 88) begin
            q[$urandom_range(q.size() - 1)] = 8'($urandom);
         end else if (kind < 94) begin
            q.delete();
            repeat ($urandom_range(8, 1)) q = {q, 8'($urandom)};
         end else begin
            repeat ($urandom_range(2)) q = {q, 8'h00};
            q = {q, 8'($urandom_range(255, 1))};
         end
         send_buffer(q);
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // null with indefinite-looking zero length, then padding
      send_buffer('{8'h05, 8'h80});
      send_buffer('{8'h04, 8'h01, 8'hFF, 8'h00});
      // complex tag on a primitive
      send_buffer('{8'h1F});
      // too many length bytes
      send_buffer('{8'h02, 8'h85});
      // child declares an end past its parent
      send_buffer('{8'h30, 8'h03, 8'h02, 8'h05});
      // explicit tag whose child header runs past the parent end
      send_buffer('{8'hA1, 8'h01, 8'h02, 8'h01});
      // largest length, buffer ends early
      send_buffer('{8'h04, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      // non-zero byte after the top object
      send_buffer('{8'h01, 8'h01, 8'hFF, 8'h07});
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 74; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 74; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         if (p == 0 || p == 3) hold_request = 1'b1;
         if (p == 0) begin
            // full stack, empty object at full depth, one level too many
            send_buffer(nest(make_prim(), MaxDepth, 1'b1));
            send_buffer(nest('{8'h30, 8'h00}, MaxDepth, 1'b1));
            send_buffer(nest(make_prim(), MaxDepth + 1, 1'b1));
         end
         run_random(TotalItems * (p + 1) / 4);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
src/asn1tlv_pkg.sv
src/asn1tlv_stack.sv
src/asn1tlv_decode.sv
src/asn1tlv_top_regs.sv
src/asn1_tlv_stream_parser_top.sv
tb/tb_asn1_tlv_stream_parser_top.sv
